// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: design/srf_pkg.sv
// Shared types and constants of the session replay filter.
package srf_pkg;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPT  = 3'd0;
    localparam logic [2:0] VERDICT_FRAME   = 3'd1;
    localparam logic [2:0] VERDICT_ID      = 3'd2;
    localparam logic [2:0] VERDICT_ZERO    = 3'd3;
    localparam logic [2:0] VERDICT_CKSUM   = 3'd4;
    localparam logic [2:0] VERDICT_REPLAY  = 3'd5;
    localparam logic [2:0] VERDICT_REVOKED = 3'd6;

    // Frame control word of an accepted packet and the lost-count ceiling
    localparam logic [15:0] FRAME_ACTION = 16'h00D0;
    localparam logic [15:0] LOST_MAX     = 16'hFFFF;

    // Configuration address map
    localparam int          ADDR_W         = 3;
    localparam logic        REG_PAIRING_ID = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Probe walking the revoked-session chain
    typedef struct packed {
        logic        valid;
        logic [31:0] session;
        logic        hit;
        logic        empty_found;
    } probe_t;

endpackage

// File: design/srf_cell.sv
// One revoked-session slot with its stage of the probe chain.
module srf_cell #(
    parameter int IDX_W      = 3,
    parameter int CELL_INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srf_pkg::probe_t      probe_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [31:0]          wr_data,
    output srf_pkg::probe_t      probe_out,
    output logic [IDX_W-1:0]     idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [31:0]      slot_reg;
    srf_pkg::probe_t  probe_reg;
    srf_pkg::probe_t  probe_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             slot_empty;

    assign slot_empty = (slot_reg == 32'd0);

    // Fold this slot into the probe: match and lowest empty slot
    always_comb
    begin
        probe_next             = probe_in;
        probe_next.hit         = probe_in.hit | (!slot_empty && (slot_reg == probe_in.session));
        probe_next.empty_found = probe_in.empty_found | slot_empty;
        idx_next               = probe_in.empty_found ? idx_in : MY_IDX;
    end

    // Slot storage, zero marks empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 32'd0;
        end
        else if (wr_en && (wr_idx == MY_IDX))
        begin
            slot_reg <= wr_data;
        end
    end

    // Probe stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            idx_reg   <= idx_next;
        end
    end

    assign probe_out = probe_reg;
    assign idx_out   = idx_reg;

endmodule

// File: design/srf_chain.sv
// Row of revoked-session cells; a probe moves one cell per cycle.
module srf_chain #(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  srf_pkg::probe_t  probe_in,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_data,
    output srf_pkg::probe_t  probe_out,
    output logic [IDX_W-1:0] idx_out
);

    srf_pkg::probe_t  link     [SLOTS+1];
    logic [IDX_W-1:0] link_idx [SLOTS+1];

    assign link[0]     = probe_in;
    assign link_idx[0] = '0;

    // Cell k takes the probe from cell k-1
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        srf_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .probe_in  (link[k]),
            .idx_in    (link_idx[k]),
            .wr_en     (wr_en),
            .wr_idx    (wr_idx),
            .wr_data   (wr_data),
            .probe_out (link[k+1]),
            .idx_out   (link_idx[k+1])
        );
    end

    assign probe_out = link[SLOTS];
    assign idx_out   = link_idx[SLOTS];

endmodule

// File: design/session_replay_filter.sv
// Session replay filter: one transaction at a time. Packets that fail a basic check, open the
// first session or belong to the current session go from the check state to the done state;
// a packet of a different session first walks the revoked-session chain, one cell per cycle.
// The done state loads the result into the output register and raises out_valid, waiting while
// out_ready stalls; the next transaction is taken the cycle after the result is registered.
// Reset (rst_n low, asynchronous) clears session, sequence, pairing ID, pointer and all slots.
module session_replay_filter #(
    parameter int REVOKED_SLOTS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // packet channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [15:0]                frame_type,
    input  logic [31:0]                packet_id,
    input  logic [31:0]                packet_session,
    input  logic [31:0]                packet_sequence,
    input  logic                       text_flag,
    input  logic                       check_good,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 verdict,
    output logic [15:0]                lost_packets,
    output logic                       session_started,
    output logic                       resync_hop,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IDX_W = (REVOKED_SLOTS > 1) ? $clog2(REVOKED_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REVOKED_SLOTS - 1);

    srf_pkg::state_t  state_reg, state_next;

    // latched packet
    logic [15:0]      ftype_reg;
    logic [31:0]      pid_reg;
    logic [31:0]      sess_reg;
    logic [31:0]      seq_reg;
    logic             text_reg;
    logic             good_reg;

    // filter state
    logic [31:0]      pairing_id_reg;
    logic [31:0]      cur_session_reg, cur_session_next;
    logic [31:0]      last_seq_reg, last_seq_next;
    logic [IDX_W-1:0] evict_ptr_reg, evict_ptr_next;

    // pending result
    logic [2:0]       res_verdict_reg, res_verdict_next;
    logic [15:0]      res_lost_reg, res_lost_next;
    logic             res_started_reg, res_started_next;
    logic             res_hop_reg, res_hop_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       verdict_reg;
    logic [15:0]      lost_reg;
    logic             started_reg;
    logic             hop_reg;
    logic             out_load;

    // chain interface
    srf_pkg::probe_t  probe_in;
    srf_pkg::probe_t  probe_out;
    logic [IDX_W-1:0] probe_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    logic             accept;
    logic             cfg_write;
    logic [31:0]      gap;
    logic [15:0]      gap_sat;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == srf_pkg::ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == srf_pkg::REG_PAIRING_ID) ? pairing_id_reg : 32'd0;

    // sequence gap minus one, saturated to 16 bits
    assign gap     = seq_reg - last_seq_reg - 32'd1;
    assign gap_sat = (gap[31:16] != 16'd0) ? srf_pkg::LOST_MAX : gap[15:0];

    srf_chain #(
        .SLOTS (REVOKED_SLOTS),
        .IDX_W (IDX_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe_in  (probe_in),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_data   (cur_session_reg),
        .probe_out (probe_out),
        .idx_out   (probe_idx)
    );

    // sequencer: checks, chain scan, result hand-off
    always_comb
    begin
        state_next        = state_reg;
        cur_session_next  = cur_session_reg;
        last_seq_next     = last_seq_reg;
        evict_ptr_next    = evict_ptr_reg;
        res_verdict_next  = res_verdict_reg;
        res_lost_next     = res_lost_reg;
        res_started_next  = res_started_reg;
        res_hop_next      = res_hop_reg;
        probe_in          = '0;
        probe_in.session  = sess_reg;
        wr_en             = 1'b0;
        wr_idx            = evict_ptr_reg;
        out_load          = 1'b0;

        case (state_reg)
            srf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = srf_pkg::ST_CHECK;
                end
            end

            srf_pkg::ST_CHECK:
            begin
                res_verdict_next = srf_pkg::VERDICT_ACCEPT;
                res_lost_next    = 16'd0;
                res_started_next = 1'b0;
                res_hop_next     = 1'b0;
                state_next       = srf_pkg::ST_DONE;
                if (ftype_reg != srf_pkg::FRAME_ACTION)
                begin
                    res_verdict_next = srf_pkg::VERDICT_FRAME;
                end
                else if (pid_reg != pairing_id_reg)
                begin
                    res_verdict_next = srf_pkg::VERDICT_ID;
                end
                else if (sess_reg == 32'd0)
                begin
                    res_verdict_next = srf_pkg::VERDICT_ZERO;
                end
                else if (!good_reg)
                begin
                    res_verdict_next = srf_pkg::VERDICT_CKSUM;
                end
                else if (cur_session_reg == 32'd0)
                begin
                    // first packet adopts its session
                    cur_session_next = sess_reg;
                    last_seq_next    = seq_reg;
                    res_started_next = 1'b1;
                end
                else if (cur_session_reg == sess_reg)
                begin
                    if (seq_reg <= last_seq_reg)
                    begin
                        res_verdict_next = srf_pkg::VERDICT_REPLAY;
                        res_hop_next     = text_reg;
                    end
                    else
                    begin
                        res_lost_next = gap_sat;
                        last_seq_next = seq_reg;
                    end
                end
                else
                begin
                    // different session: look it up in the revoked list
                    probe_in.valid = 1'b1;
                    state_next     = srf_pkg::ST_SCAN;
                end
            end

            srf_pkg::ST_SCAN:
            begin
                if (probe_out.valid)
                begin
                    state_next = srf_pkg::ST_DONE;
                    if (probe_out.hit)
                    begin
                        res_verdict_next = srf_pkg::VERDICT_REVOKED;
                    end
                    else
                    begin
                        // revoke the old session, then adopt the new one
                        wr_en = 1'b1;
                        if (probe_out.empty_found)
                        begin
                            wr_idx = probe_idx;
                        end
                        else
                        begin
                            evict_ptr_next = (evict_ptr_reg == LAST_IDX) ? '0
                                                                        : evict_ptr_reg + 1'b1;
                        end
                        cur_session_next = sess_reg;
                        last_seq_next    = seq_reg;
                        res_started_next = 1'b1;
                    end
                end
            end

            srf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = srf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = srf_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srf_pkg::ST_IDLE;
            pairing_id_reg  <= 32'd0;
            cur_session_reg <= 32'd0;
            last_seq_reg    <= 32'd0;
            evict_ptr_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_session_reg <= cur_session_next;
            last_seq_reg    <= last_seq_next;
            evict_ptr_reg   <= evict_ptr_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write && (paddr[2] == srf_pkg::REG_PAIRING_ID))
            begin
                pairing_id_reg <= pwdata;
            end
        end
    end

    // packet latch, pending result and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ftype_reg <= frame_type;
            pid_reg   <= packet_id;
            sess_reg  <= packet_session;
            seq_reg   <= packet_sequence;
            text_reg  <= text_flag;
            good_reg  <= check_good;
        end
        res_verdict_reg <= res_verdict_next;
        res_lost_reg    <= res_lost_next;
        res_started_reg <= res_started_next;
        res_hop_reg     <= res_hop_next;
        if (out_load)
        begin
            verdict_reg <= res_verdict_reg;
            lost_reg    <= res_lost_reg;
            started_reg <= res_started_reg;
            hop_reg     <= res_hop_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign lost_packets    = lost_reg;
    assign session_started = started_reg;
    assign resync_hop      = hop_reg;

endmodule

// File: design/srf_checker.sv
// Port-level checker for the session replay filter, bound to the top level.
`include "assert_macros.svh"

module srf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  verdict,
    input logic [15:0] lost_packets,
    input logic        session_started,
    input logic        resync_hop
);

    // stalled result stays offered and unchanged
    `SRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SRF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(verdict) && $stable(lost_packets) && $stable(session_started) && $stable(resync_hop))

    // one packet in flight: no acceptance right after one
    `SRF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new session is only reported on an accepted packet with no loss
    `SRF_ASSERT_IMPLY(a_start_accept, clk, rst_n, out_valid && session_started, (verdict == srf_pkg::VERDICT_ACCEPT) && (lost_packets == 16'd0))

    // resync request only on a replay
    `SRF_ASSERT_IMPLY(a_hop_replay, clk, rst_n, out_valid && resync_hop, verdict == srf_pkg::VERDICT_REPLAY)

endmodule

bind session_replay_filter srf_checker u_srf_checker (.*);
